### rtl/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear image resize block: transaction
// payload structs, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int SRC_W_REG_W = 9;
    localparam int SRC_H_REG_W = 7;
    localparam int DST_REG_W   = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    localparam logic [SRC_W_REG_W-1:0] SRC_WIDTH_RST  = 9'd256;
    localparam logic [SRC_H_REG_W-1:0] SRC_HEIGHT_RST = 7'd64;
    localparam logic [DST_REG_W-1:0]   DST_WIDTH_RST  = 11'd256;
    localparam logic [DST_REG_W-1:0]   DST_HEIGHT_RST = 11'd64;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/bilinear_image_resize.sv
// ----------------------------------------------------------------------------
// bilinear_image_resize
// A pixel request runs position multiply, split, six blend steps reading one
//   neighbor a cycle from the single-port store, and round, then waits for
//   the output register; in_ready stays low until its result is loaded.
// One write per cycle while in_ready is high.
// Reset, and every config write, runs the shared scale divider for column
//   then row with in_ready low.
// The pixel store is not cleared; an entry is valid once written.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_resize #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 64,
    parameter int MAX_DST_SIZE   = 1024,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bir_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire bir_pkg::t_in_item                i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output bir_pkg::t_out_item                    o_out_item
);

    import bir_pkg::*;

    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int SWV_W = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHV_W = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DDW   = $clog2(MAX_DST_SIZE + 1);
    localparam int DSW   = $clog2(MAX_DST_SIZE);
    localparam int MXW   = (XW > YW) ? XW : YW;
    localparam int DVW   = MXW + FRAC_BITS;
    localparam int PWC   = COL_W + DVW;
    localparam int PWR   = ROW_W + DVW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = FRAC_BITS + 1;
    localparam int W2W   = 2 * WW;
    localparam int PRW   = W2W + PIX_W;
    localparam int ACW   = PRW + 2;
    localparam int TOPW  = ACW - 2 * FRAC_BITS;

    localparam logic [WW-1:0]  ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACW-1:0] HALF    = ACW'(1) << (2 * FRAC_BITS - 1);
    localparam logic [2:0]     LAST_STEP = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POS   = 5'b00010,
        ST_SPLIT = 5'b00100,
        ST_BLEND = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_COL  = 3'b010,
        SC_ROW  = 3'b100
    } t_sc_state;

    // configuration and scales
    logic [SRC_W_REG_W-1:0] r_src_width;
    logic [SRC_H_REG_W-1:0] r_src_height;
    logic [DST_REG_W-1:0]   r_dst_width;
    logic [DST_REG_W-1:0]   r_dst_height;
    logic [DVW-1:0]         r_col_scale;
    logic [DVW-1:0]         r_row_scale;
    t_sc_state              r_sc_state;
    logic                   r_kick;

    logic [SWV_W-1:0] eff_sw;
    logic [SHV_W-1:0] eff_sh;
    logic [DDW-1:0]   eff_dw;
    logic [DDW-1:0]   eff_dh;
    logic [XW-1:0]    sw_m1;
    logic [YW-1:0]    sh_m1;

    logic             div_start;
    logic [DVW-1:0]   div_dividend;
    logic [DSW-1:0]   div_divisor;
    logic             div_done;
    logic [DVW-1:0]   div_quo;

    // request datapath
    t_state           r_state;
    t_state           n_state;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PWC-1:0]   r_px;
    logic [PWR-1:0]   r_py;
    logic [XW-1:0]    r_x;
    logic [YW-1:0]    r_y;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;
    logic             r_single;
    logic [2:0]       r_step;
    logic [W2W-1:0]   r_w;
    logic [PRW-1:0]   r_prod;
    logic [ACW-1:0]   r_acc;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;

    logic             in_acc;
    logic             out_free;
    logic [PWC-FRAC_BITS-1:0] ipx;
    logic [PWR-FRAC_BITS-1:0] ipy;
    logic             x_sat;
    logic             y_sat;
    logic [XW-1:0]    x_cl;
    logic [YW-1:0]    y_cl;
    logic             inc_c;
    logic             inc_r;
    logic [XW-1:0]    nb_col;
    logic [YW-1:0]    nb_row;
    logic [WW-1:0]    gx;
    logic [WW-1:0]    gy;
    logic [WW-1:0]    wa;
    logic [WW-1:0]    wb;
    logic [TOPW-1:0]  acc_top;
    logic [PIX_W-1:0] val;

    // ---------------- effective sizes ----------------
    always_comb begin
        if (r_src_width == '0) begin
            eff_sw = SWV_W'(1);
        end else if (32'(r_src_width) > MAX_SRC_WIDTH) begin
            eff_sw = SWV_W'(MAX_SRC_WIDTH);
        end else begin
            eff_sw = SWV_W'(r_src_width);
        end
        if (r_src_height == '0) begin
            eff_sh = SHV_W'(1);
        end else if (32'(r_src_height) > MAX_SRC_HEIGHT) begin
            eff_sh = SHV_W'(MAX_SRC_HEIGHT);
        end else begin
            eff_sh = SHV_W'(r_src_height);
        end
        if (r_dst_width < DST_REG_W'(2)) begin
            eff_dw = DDW'(2);
        end else if (32'(r_dst_width) > MAX_DST_SIZE) begin
            eff_dw = DDW'(MAX_DST_SIZE);
        end else begin
            eff_dw = DDW'(r_dst_width);
        end
        if (r_dst_height < DST_REG_W'(2)) begin
            eff_dh = DDW'(2);
        end else if (32'(r_dst_height) > MAX_DST_SIZE) begin
            eff_dh = DDW'(MAX_DST_SIZE);
        end else begin
            eff_dh = DDW'(r_dst_height);
        end
        sw_m1 = XW'(eff_sw - 1'b1);
        sh_m1 = YW'(eff_sh - 1'b1);
    end

    // ---------------- scale sequencer ----------------
    // column ratio first, then row; a config write aborts and restarts
    always_comb begin
        div_start = 1'b0;
        if (!i_cfg_we) begin
            if (r_sc_state == SC_IDLE && r_kick) begin
                div_start = 1'b1;
            end else if (r_sc_state == SC_COL && div_done) begin
                div_start = 1'b1;
            end
        end
        if (r_sc_state == SC_COL) begin
            div_dividend = DVW'(sh_m1) << FRAC_BITS;
            div_divisor  = DSW'(eff_dh - 1'b1);
        end else begin
            div_dividend = DVW'(sw_m1) << FRAC_BITS;
            div_divisor  = DSW'(eff_dw - 1'b1);
        end
    end

    bir_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_dst_width  <= DST_WIDTH_RST;
            r_dst_height <= DST_HEIGHT_RST;
            r_sc_state   <= SC_IDLE;
            r_kick       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_wdata[SRC_W_REG_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_wdata[SRC_H_REG_W-1:0];
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_wdata[DST_REG_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_wdata[DST_REG_W-1:0];
                default: ;
            endcase
            r_sc_state <= SC_IDLE;
            r_kick     <= 1'b1;
        end else begin
            unique case (r_sc_state)
                SC_IDLE: begin
                    if (r_kick) begin
                        r_sc_state <= SC_COL;
                        r_kick     <= 1'b0;
                    end
                end
                SC_COL: begin
                    if (div_done) begin
                        r_sc_state <= SC_ROW;
                    end
                end
                SC_ROW: begin
                    if (div_done) begin
                        r_sc_state <= SC_IDLE;
                    end
                end
                default: r_sc_state <= SC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done && r_sc_state == SC_COL) begin
            r_col_scale <= div_quo;
        end
        if (div_done && r_sc_state == SC_ROW) begin
            r_row_scale <= div_quo;
        end
    end

    // ---------------- handshake ----------------
    assign o_in_ready = (r_state == ST_IDLE) && (r_sc_state == SC_IDLE) && !r_kick;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // ---------------- position split ----------------
    always_comb begin
        ipx   = r_px[PWC-1:FRAC_BITS];
        ipy   = r_py[PWR-1:FRAC_BITS];
        x_sat = (ipx >= (PWC-FRAC_BITS)'(sw_m1));
        y_sat = (ipy >= (PWR-FRAC_BITS)'(sh_m1));
        x_cl  = x_sat ? sw_m1 : ipx[XW-1:0];
        y_cl  = y_sat ? sh_m1 : ipy[YW-1:0];
    end

    // ---------------- neighbor address and weight ----------------
    always_comb begin
        inc_c  = r_step[0] & ~r_single;
        inc_r  = r_step[1] & ~r_single;
        nb_col = r_x + XW'(inc_c);
        nb_row = r_y + YW'(inc_r);
        gx     = ONE_FIX - {1'b0, r_fx};
        gy     = ONE_FIX - {1'b0, r_fy};
        wa     = r_step[0] ? {1'b0, r_fx} : gx;
        wb     = r_step[1] ? {1'b0, r_fy} : gy;
        if (r_state == ST_BLEND) begin
            mem_addr = AW'(AW'(nb_row) * AW'(MAX_SRC_WIDTH)) + AW'(nb_col);
        end else begin
            mem_addr = AW'(AW'(i_in_item.row) * AW'(MAX_SRC_WIDTH)) + AW'(i_in_item.col);
        end
        mem_we = in_acc && (i_in_item.kind == KIND_WRITE)
                 && (32'(i_in_item.col) < 32'(eff_sw))
                 && (32'(i_in_item.row) < 32'(eff_sh));
        acc_top = r_acc[ACW-1:2*FRAC_BITS];
        val     = (acc_top > TOPW'(255)) ? PIX_W'(255) : acc_top[PIX_W-1:0];
    end

    // ---------------- pixel store ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_in_item.pixel_in;
        end
        r_rdata <= mem[mem_addr];
    end

    // ---------------- request sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_item.kind == KIND_READ) begin
                    n_state = ST_POS;
                end
            end
            ST_POS:   n_state = ST_SPLIT;
            ST_SPLIT: n_state = ST_BLEND;
            ST_BLEND: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col <= i_in_item.col;
            r_row <= i_in_item.row;
        end
        if (r_state == ST_POS) begin
            r_px <= PWC'(r_col) * PWC'(r_col_scale);
            r_py <= PWR'(r_row) * PWR'(r_row_scale);
        end
        if (r_state == ST_SPLIT) begin
            r_x      <= x_cl;
            r_y      <= y_cl;
            r_single <= x_sat || y_sat;
            // single-pixel path: zero fractions leave full weight on (x,y)
            r_fx     <= (x_sat || y_sat) ? '0 : r_px[FRAC_BITS-1:0];
            r_fy     <= (x_sat || y_sat) ? '0 : r_py[FRAC_BITS-1:0];
            r_step   <= '0;
            r_acc    <= HALF;
        end
        if (r_state == ST_BLEND) begin
            r_step <= r_step + 1'b1;
            // step s: read neighbor s; s+1: weight times pixel; s+2: accumulate
            if (r_step < 3'd4) begin
                r_w <= W2W'(wa) * W2W'(wb);
            end
            if (r_step >= 3'd1 && r_step <= 3'd4) begin
                r_prod <= PRW'(r_w) * PRW'(r_rdata);
            end
            if (r_step >= 3'd2) begin
                r_acc <= r_acc + ACW'(r_prod);
            end
        end
        if (r_state == ST_DONE && out_free) begin
            r_out.pixel_out <= val;
            r_out.out_col   <= r_col;
            r_out.out_row   <= r_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_single_no_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLEND && r_single) |-> (r_fx == '0 && r_fy == '0))
        else $error("single-pixel path carries a fraction");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the done state");

    a_blend_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLEND && r_step == LAST_STEP) |=> (r_state == ST_DONE))
        else $error("blend sequence overran");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_IDLE && r_sc_state == SC_IDLE))
        else $error("store written during a request or scale update");

endmodule

`default_nettype wire

### rtl/bir_div.sv
// ----------------------------------------------------------------------------
// bir_div
// Restoring unsigned divider, one quotient bit per cycle. A start loads the
// operands and restarts a division in progress; done pulses with the
// quotient valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_div #(
    parameter int DVW = 24,
    parameter int DSW = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DVW-1:0] i_dividend,
    input  wire logic [DSW-1:0] i_divisor,
    output logic                o_done,
    output logic      [DVW-1:0] o_quotient
);

    localparam int CNTW = $clog2(DVW + 1);

    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic [DVW-1:0]  r_quo;
    logic [DSW-1:0]  r_rem;
    logic [DSW-1:0]  r_dsr;

    logic [DSW:0]    rem_sh;
    logic [DSW:0]    rem_sub;
    logic            qbit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DVW-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
        qbit    = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNTW'(DVW);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNTW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVW-2:0], qbit};
            r_rem <= qbit ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_cnt == '0))
        else $error("divider done while bits remain");

    a_start_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_cnt == CNTW'(DVW)) && !o_done)
        else $error("divider start did not load the bit count");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && !i_start) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("divider bit count skipped");

endmodule

`default_nettype wire

### sim/bilinear_image_resize_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_tb
// Self-checking bench for the bilinear resize block. Source pixels are loaded
// through write transactions and destination pixels are requested. A local
// model of the store, the scale ratios and the blend predicts every result,
// which is checked in order against the output channel. Runs directed corner
// cases, then random phases over many source/destination size settings.
// ----------------------------------------------------------------------------
module bilinear_image_resize_tb;
    import bir_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int FRAC_BITS      = 16;
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 64;
    localparam int MAX_DST_SIZE   = 1024;
    localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int DRAIN_CYCLES   = 12;
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 200;
    localparam int QUIET_PHASE    = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;

    bilinear_image_resize i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // shadow of the block's registers and store
    logic [SRC_W_REG_W-1:0] src_w_reg;
    logic [SRC_H_REG_W-1:0] src_h_reg;
    logic [DST_REG_W-1:0]   dst_w_reg;
    logic [DST_REG_W-1:0]   dst_h_reg;
    int unsigned            src_w_eff;
    int unsigned            src_h_eff;
    int unsigned            dst_w_eff;
    int unsigned            dst_h_eff;
    longint unsigned        col_scale;
    longint unsigned        row_scale;
    logic [PIX_W-1:0]       src_image [STORE_DEPTH];
    bit                     src_loaded [STORE_DEPTH];

    t_out_item pending_results [$];
    int        mismatch_cnt = 0;
    int        stall_cycles = 0;
    bit        idle_en      = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lo,
                                               input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned scale_ratio(input int unsigned src,
                                                    input int unsigned dst);
        longint unsigned num;
        longint unsigned den;
        num = src - 1;
        den = dst - 1;
        return (num << FRAC_BITS) / den;
    endfunction

    function automatic void update_scales();
        src_w_eff = clamp_size(src_w_reg, 1, MAX_SRC_WIDTH);
        src_h_eff = clamp_size(src_h_reg, 1, MAX_SRC_HEIGHT);
        dst_w_eff = clamp_size(dst_w_reg, 2, MAX_DST_SIZE);
        dst_h_eff = clamp_size(dst_h_reg, 2, MAX_DST_SIZE);
        col_scale = scale_ratio(src_w_eff, dst_w_eff);
        row_scale = scale_ratio(src_h_eff, dst_h_eff);
    endfunction

    function automatic int unsigned pixel_addr(input int unsigned x, input int unsigned y);
        return y * MAX_SRC_WIDTH + x;
    endfunction

    // top-left source neighbor, weights and whether only one pixel is used
    function automatic void locate_neighbors(input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row,
                                             output int unsigned x, output int unsigned y,
                                             output longint unsigned fx,
                                             output longint unsigned fy,
                                             output bit single);
        longint unsigned cx;
        longint unsigned cy;
        longint unsigned px;
        longint unsigned py;
        cx = col;
        cy = row;
        px = cx * col_scale;
        py = cy * row_scale;
        fx = px & ((64'd1 << FRAC_BITS) - 1);
        fy = py & ((64'd1 << FRAC_BITS) - 1);
        px = px >> FRAC_BITS;
        py = py >> FRAC_BITS;
        x = (px >= src_w_eff - 1) ? src_w_eff - 1 : int'(px);
        y = (py >= src_h_eff - 1) ? src_h_eff - 1 : int'(py);
        single = (x == src_w_eff - 1) || (y == src_h_eff - 1);
    endfunction

    function automatic logic [PIX_W-1:0] resize_pixel(input logic [COL_W-1:0] col,
                                                      input logic [ROW_W-1:0] row);
        int unsigned     x;
        int unsigned     y;
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned gx;
        longint unsigned gy;
        longint unsigned acc;
        bit              single;
        locate_neighbors(col, row, x, y, fx, fy, single);
        if (single) return src_image[pixel_addr(x, y)];
        gx  = (64'd1 << FRAC_BITS) - fx;
        gy  = (64'd1 << FRAC_BITS) - fy;
        acc = gx * gy * src_image[pixel_addr(x, y)]
            + fx * gy * src_image[pixel_addr(x + 1, y)]
            + gx * fy * src_image[pixel_addr(x, y + 1)]
            + fx * fy * src_image[pixel_addr(x + 1, y + 1)];
        acc = (acc + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        return (acc > 255) ? 8'hFF : acc[PIX_W-1:0];
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            if (mismatch_cnt < MAX_REPORTS)
                $display("unexpected result: pixel %0d col %0d row %0d",
                         got.pixel_out, got.out_col, got.out_row);
            mismatch_cnt++;
            return;
        end
        want = pending_results.pop_front();
        if (got.pixel_out !== want.pixel_out || got.out_col !== want.out_col ||
            got.out_row !== want.out_row) begin
            if (mismatch_cnt < MAX_REPORTS)
                $display("mismatch: expected pixel %0d col %0d row %0d, got pixel %0d col %0d row %0d",
                         want.pixel_out, want.out_col, want.out_row,
                         got.pixel_out, got.out_col, got.out_row);
            mismatch_cnt++;
        end
    endfunction

    // result channel: check and throttle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_item);
        i_out_ready <= !idle_en || ($urandom_range(0, 99) >= 38);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[bilinear_image_resize] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input t_in_item item);
        t_out_item want;
        while (idle_en && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (item.kind == KIND_WRITE) begin
            // writes beyond the source size are dropped by the block
            if (item.col < src_w_eff && item.row < src_h_eff) begin
                src_image[pixel_addr(item.col, item.row)]  = item.pixel_in;
                src_loaded[pixel_addr(item.col, item.row)] = 1'b1;
            end
        end else begin
            want.pixel_out = resize_pixel(item.col, item.row);
            want.out_col   = item.col;
            want.out_row   = item.row;
            pending_results.push_back(want);
        end
    endtask

    task automatic write_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                               input logic [PIX_W-1:0] pix);
        t_in_item item;
        item.kind     = KIND_WRITE;
        item.col      = col;
        item.row      = row;
        item.pixel_in = pix;
        send_item(item);
    endtask

    // loads any neighbor the request reads that was never written, then asks
    task automatic request_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        t_in_item        item;
        int unsigned     x;
        int unsigned     y;
        longint unsigned fx;
        longint unsigned fy;
        bit              single;
        int unsigned     span;
        locate_neighbors(col, row, x, y, fx, fy, single);
        span = single ? 0 : 1;
        for (int unsigned dy = 0; dy <= span; dy++) begin
            for (int unsigned dx = 0; dx <= span; dx++) begin
                if (!src_loaded[pixel_addr(x + dx, y + dy)])
                    write_pixel(x + dx, y + dy, $urandom_range(0, 255));
            end
        end
        item.kind     = KIND_READ;
        item.col      = col;
        item.row      = row;
        item.pixel_in = $urandom_range(0, 255);
        send_item(item);
    endtask

    task automatic wait_ready();
        repeat (4) @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  src_w_reg = data[SRC_W_REG_W-1:0];
            CFG_SRC_HEIGHT: src_h_reg = data[SRC_H_REG_W-1:0];
            CFG_DST_WIDTH:  dst_w_reg = data[DST_REG_W-1:0];
            CFG_DST_HEIGHT: dst_h_reg = data[DST_REG_W-1:0];
            default: ;
        endcase
        update_scales();
        // the scale divider holds off input after each write
        wait_ready();
    endtask

    task automatic set_sizes(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                             input logic [CFG_DATA_W-1:0] dw, input logic [CFG_DATA_W-1:0] dh);
        drain();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
    endtask

    // reset sizes give a ratio of exactly one, so edges hit the last row/column
    task automatic test_reset_sizes();
        write_pixel(0, 0, 8'h00);
        write_pixel(MAX_SRC_WIDTH - 1, MAX_SRC_HEIGHT - 1, 8'hFF);
        write_pixel(10'h3FF, 10'h3FF, 8'hAA);
        request_pixel(0, 0);
        request_pixel(MAX_SRC_WIDTH - 1, MAX_SRC_HEIGHT - 1);
        request_pixel(10'h3FF, 10'h3FF);
        request_pixel(MAX_SRC_WIDTH - 2, MAX_SRC_HEIGHT - 2);
    endtask

    task automatic test_ignored_writes();
        write_pixel(10, 0, 8'h5A);
        set_sizes(4, MAX_SRC_HEIGHT, 256, 64);
        write_pixel(10, 0, 8'hA5);
        set_sizes(MAX_SRC_WIDTH, MAX_SRC_HEIGHT, 256, 64);
        request_pixel(10, 0);
    endtask

    // 2x2 source onto 3x3 lands exactly halfway between neighbors
    task automatic test_rounding();
        set_sizes(2, 2, 3, 3);
        write_pixel(0, 0, 8'd0);
        write_pixel(1, 0, 8'd1);
        write_pixel(0, 1, 8'd0);
        write_pixel(1, 1, 8'd1);
        request_pixel(1, 0);
        request_pixel(1, 1);
        request_pixel(2, 2);
        for (int i = 0; i < 4; i++) write_pixel(i % 2, i / 2, 8'hFF);
        request_pixel(1, 1);
    endtask

    task automatic test_size_saturation();
        set_sizes(0, 0, 11'h7FF, 11'h7FF);
        request_pixel(10'h3FF, 10'h3FF);
        request_pixel(0, 0);
        set_sizes(11'h7FF, 11'h7F, 1, 0);
        request_pixel(1, 1);
        request_pixel(0, 0);
        request_pixel(0, 1);
        set_sizes(MAX_SRC_WIDTH, MAX_SRC_HEIGHT, MAX_DST_SIZE, MAX_DST_SIZE);
        request_pixel(10'h3FF, 10'h3FF);
        request_pixel(10'h3FE, 10'h001);
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: set_sizes($urandom_range(1, 8), $urandom_range(1, 8),
                             $urandom_range(2, 16), $urandom_range(2, 16));
                1: set_sizes($urandom_range(1, MAX_SRC_WIDTH), $urandom_range(1, MAX_SRC_HEIGHT),
                             $urandom_range(2, MAX_DST_SIZE), $urandom_range(2, MAX_DST_SIZE));
                2: set_sizes($urandom_range(0, 2047), $urandom_range(0, 2047),
                             $urandom_range(0, 2047), $urandom_range(0, 2047));
                default: set_sizes($urandom_range(0, 1) ? MAX_SRC_WIDTH : 1,
                                   $urandom_range(0, 1) ? MAX_SRC_HEIGHT : 2,
                                   $urandom_range(0, 1) ? MAX_DST_SIZE : 2,
                                   $urandom_range(0, 1) ? MAX_DST_SIZE : 2);
            endcase
            idle_en = (ph != QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 14) begin
                    write_pixel($urandom_range(0, src_w_eff - 1), $urandom_range(0, src_h_eff - 1),
                                $urandom_range(0, 255));
                end else if (pick < 20) begin
                    write_pixel($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 255));
                end else if (pick < 88) begin
                    request_pixel($urandom_range(0, dst_w_eff - 1),
                                  $urandom_range(0, dst_h_eff - 1));
                end else begin
                    request_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
                end
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_SRC_WIDTH;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;
        src_w_reg = SRC_WIDTH_RST;
        src_h_reg = SRC_HEIGHT_RST;
        dst_w_reg = DST_WIDTH_RST;
        dst_h_reg = DST_HEIGHT_RST;
        update_scales();
        for (int i = 0; i < STORE_DEPTH; i++) begin
            src_image[i]  = '0;
            src_loaded[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_ready();

        test_reset_sizes();
        test_ignored_writes();
        test_rounding();
        test_size_saturation();
        test_random_traffic();
        drain();

        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("[bilinear_image_resize] OK");
        end else begin
            $display("[bilinear_image_resize] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bir_pkg.sv
rtl/bir_div.sv
rtl/bilinear_image_resize.sv
sim/bilinear_image_resize_tb.sv
